[rtl/lnr_pkg.sv]
package lnr_pkg;

   // default sizes
   localparam int TAPS_DEF      = 64;
   localparam int BUF_DEPTH_DEF = 256;

   // quotient bits of the step-size divide
   localparam int DIV_STEPS = 31;

   // register indexes
   localparam logic [2:0] REG_NOTCH_MODE = 3'd0;
   localparam logic [2:0] REG_DELAY_TAPS = 3'd1;
   localparam logic [2:0] REG_TWO_MU     = 3'd2;
   localparam logic [2:0] REG_LEAK_SCALE = 3'd3;
   localparam logic [2:0] REG_LIDX_MIN   = 3'd4;
   localparam logic [2:0] REG_LIDX_MAX   = 3'd5;
   localparam logic [2:0] REG_LIDX_INC   = 3'd6;
   localparam logic [2:0] REG_LIDX_DEC   = 3'd7;

   // register reset values
   localparam logic        NOTCH_MODE_RST = 1'b0;
   localparam logic [7:0]  DELAY_TAPS_RST = 8'd16;
   localparam logic [23:0] TWO_MU_RST     = 24'd1678;
   localparam logic [31:0] LEAK_SCALE_RST = 32'd17592;
   localparam logic [7:0]  LIDX_MIN_RST   = 8'd120;
   localparam logic [7:0]  LIDX_MAX_RST   = 8'd200;
   localparam logic [7:0]  LIDX_INC_RST   = 8'd1;
   localparam logic [7:0]  LIDX_DEC_RST   = 8'd3;

   // leakage index after reset
   localparam logic [7:0]  LIDX_RESET     = 8'd120;

   typedef struct packed {
      logic        notch_mode;
      logic [7:0]  delay_taps;
      logic [23:0] two_mu;
      logic [31:0] leak_scale;
      logic [7:0]  lidx_min;
      logic [7:0]  lidx_max;
      logic [7:0]  lidx_inc;
      logic [7:0]  lidx_dec;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic clr;
      logic load;
      logic start;
      logic rd;
      logic pass2;
      logic latch_err;
      logic calc_g;
      logic load_out;
      logic err_mul;
      logic err_cmp;
      logic gam1;
      logic gam2;
      logic gam3;
      logic gam4;
      logic div_init;
      logic div_step;
      logic wi_step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sigma_zero;
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DOT,
      S_RESULT,
      S_ERRMUL,
      S_ERRCMP,
      S_GAM1,
      S_GAM2,
      S_GAM3,
      S_GAM4,
      S_GMU,
      S_DIVINIT,
      S_DIV,
      S_PREP2,
      S_UPD,
      S_FIN
   } state_type;

endpackage

[rtl/lnr_ctrl.sv]
module lnr_ctrl #(
   parameter int TAPS      = lnr_pkg::TAPS_DEF,
   parameter int BUF_DEPTH = lnr_pkg::BUF_DEPTH_DEF,
   localparam int CLRN     = (BUF_DEPTH > TAPS) ? BUF_DEPTH : TAPS,
   localparam int CW       = $clog2(CLRN + 3)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  lnr_pkg::status_type  status,
   output lnr_pkg::cmd_type     cmd,
   output logic [CW-1:0]        cnt
);

   lnr_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               can_load;

   // state, step counter and result flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lnr_pkg::S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign can_load = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         lnr_pkg::S_CLEAR: begin
            cmd.clr = 1'b1;
            if (cnt_ff == CW'(CLRN - 1)) state_in = lnr_pkg::S_IDLE;
         end
         lnr_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load  = 1'b1;
               cmd.start = 1'b1;
               state_in  = lnr_pkg::S_DOT;
            end
         end
         lnr_pkg::S_DOT: begin
            cmd.rd = (cnt_ff < CW'(TAPS));
            if (cnt_ff == CW'(TAPS + 1)) state_in = lnr_pkg::S_RESULT;
         end
         lnr_pkg::S_RESULT: begin
            if (can_load) begin
               cmd.latch_err = 1'b1;
               cmd.calc_g    = 1'b1;
               cmd.load_out  = 1'b1;
               state_in      = lnr_pkg::S_ERRMUL;
            end
         end
         lnr_pkg::S_ERRMUL: begin
            cmd.err_mul = 1'b1;
            state_in    = lnr_pkg::S_ERRCMP;
         end
         lnr_pkg::S_ERRCMP: begin
            cmd.err_cmp = 1'b1;
            state_in    = lnr_pkg::S_GAM1;
         end
         lnr_pkg::S_GAM1: begin
            cmd.gam1 = 1'b1;
            state_in = lnr_pkg::S_GAM2;
         end
         lnr_pkg::S_GAM2: begin
            cmd.gam2 = 1'b1;
            state_in = lnr_pkg::S_GAM3;
         end
         lnr_pkg::S_GAM3: begin
            cmd.gam3 = 1'b1;
            state_in = lnr_pkg::S_GAM4;
         end
         lnr_pkg::S_GAM4: begin
            cmd.gam4 = 1'b1;
            state_in = lnr_pkg::S_GMU;
         end
         lnr_pkg::S_GMU: begin
            cmd.calc_g = 1'b1;
            state_in   = lnr_pkg::S_DIVINIT;
         end
         lnr_pkg::S_DIVINIT: begin
            cmd.div_init = 1'b1;
            state_in = status.sigma_zero ? lnr_pkg::S_PREP2 : lnr_pkg::S_DIV;
         end
         lnr_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CW'(lnr_pkg::DIV_STEPS - 1)) state_in = lnr_pkg::S_PREP2;
         end
         lnr_pkg::S_PREP2: begin
            cmd.start = 1'b1;
            state_in  = lnr_pkg::S_UPD;
         end
         lnr_pkg::S_UPD: begin
            cmd.pass2 = 1'b1;
            cmd.rd    = (cnt_ff < CW'(TAPS));
            if (cnt_ff == CW'(TAPS + 1)) state_in = lnr_pkg::S_FIN;
         end
         lnr_pkg::S_FIN: begin
            cmd.wi_step = 1'b1;
            state_in    = lnr_pkg::S_IDLE;
         end
         default: state_in = lnr_pkg::S_IDLE;
      endcase
   end

   // counter restarts on every state change
   always_comb begin
      if (state_in != state_ff) cnt_in = '0;
      else                      cnt_in = cnt_ff + CW'(1);
   end

   // result flag
   always_comb begin
      if (cmd.load_out)  rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else               rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign cnt       = cnt_ff;

endmodule

[rtl/lnr_dp.sv]
module lnr_dp #(
   parameter int TAPS      = lnr_pkg::TAPS_DEF,
   parameter int BUF_DEPTH = lnr_pkg::BUF_DEPTH_DEF,
   localparam int CLRN     = (BUF_DEPTH > TAPS) ? BUF_DEPTH : TAPS,
   localparam int CW       = $clog2(CLRN + 3)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lnr_pkg::cfg_type     cfg,
   input  lnr_pkg::cmd_type     cmd,
   input  logic [CW-1:0]        cnt,
   input  logic signed [15:0]   sample_in,
   output logic signed [15:0]   sample_out,
   output lnr_pkg::status_type  status
);

   localparam int AW   = $clog2(BUF_DEPTH);
   localparam int TW   = $clog2(TAPS);
   localparam int SW   = ((AW > 8) ? AW : 8) + 1;
   localparam int ACCW = 48 + TW;
   localparam int SIGW = 31 + TW;
   localparam int YW   = ACCW - 30;
   localparam int EW   = YW + 1;
   localparam int PW   = EW + 26;
   localparam int NW   = PW + 2;
   localparam int NUMW = EW + 25;
   localparam int DW   = (NUMW > SIGW + 10) ? NUMW : SIGW + 10;
   localparam int QW   = lnr_pkg::DIV_STEPS;

   // memories
   logic signed [15:0] line_mem [BUF_DEPTH];
   logic signed [31:0] w_mem    [TAPS];

   // pointers
   logic [AW-1:0] wi_ff, addr_ff;
   logic [SW-1:0] base_c;
   // window read and pipeline
   logic signed [15:0] x_rd_ff, x0_ff;
   logic signed [31:0] w_rd_ff;
   logic               s1_ff, s2_ff, p1_ff, p2_ff;
   logic [TW-1:0]      j1_ff, j2_ff;
   logic signed [47:0] prod_ff, px_ff;
   logic signed [31:0] sq_c;
   logic [30:0]        sq_ff;
   logic signed [57:0] pw_ff;
   logic signed [ACCW-1:0] acc_ff, accr_c;
   logic [SIGW-1:0]    sigma_ff;
   // error terms
   logic signed [YW-1:0] y_c, y_ff;
   logic signed [EW-1:0] e_c, e_ff, res_c;
   logic signed [15:0]   out_ff;
   logic [23:0]          g_ff, m_c;
   logic [55:0]          gmul_c;
   logic [24:0]          ck_c, km_c;
   logic signed [PW-1:0] nelp_ff, gy_ff;
   logic signed [NUMW-1:0] num_ff;
   logic signed [NW-1:0] nev_s, nel_s;
   logic [NW-1:0]        nev_a, nel_a;
   // leakage
   logic [7:0]           idx_ff, idx_c;
   logic [8:0]           up_c;
   logic signed [9:0]    dn_c;
   logic [15:0]          i2_ff;
   logic [31:0]          i4_ff, gamma_ff;
   logic [63:0]          lg_ff;
   // divider
   logic [NUMW-1:0]      an_c;
   logic [SIGW-1:0]      rem_ff;
   logic [SIGW:0]        trial_c;
   logic [QW-1:0]        dq_ff, q_ff;
   logic                 zero_ff, sat_ff, neg_ff;
   logic [QW-1:0]        mag_c;
   logic signed [31:0]   c1_c;
   // weight update
   logic signed [57:0]   pwr_c;
   logic signed [47:0]   pxr_c;
   logic signed [33:0]   wa_c;
   logic signed [32:0]   wb_c;
   logic signed [34:0]   wsum_c;
   logic signed [31:0]   wnew_c;

   // window start, wrapped into the line store
   always_comb begin
      base_c = SW'(wi_ff) + SW'(cfg.delay_taps);
      for (int k = 0; k < 4; k++) begin
         if (base_c >= SW'(BUF_DEPTH)) base_c = base_c - SW'(BUF_DEPTH);
      end
   end

   // pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff <= '0;
      end else if (cmd.wi_step) begin
         wi_ff <= (wi_ff == '0) ? AW'(BUF_DEPTH - 1) : wi_ff - AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) addr_ff <= base_c[AW-1:0];
      else if (cmd.rd) addr_ff <= (addr_ff == AW'(BUF_DEPTH - 1)) ? '0 : addr_ff + AW'(1);
   end

   // line store
   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         if (cnt < CW'(BUF_DEPTH)) line_mem[cnt[AW-1:0]] <= '0;
      end else if (cmd.load) begin
         line_mem[wi_ff] <= sample_in;
      end
      if (cmd.rd) x_rd_ff <= line_mem[addr_ff];
   end

   // tap weights
   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         if (cnt < CW'(TAPS)) w_mem[cnt[TW-1:0]] <= '0;
      end else if (s2_ff && p2_ff) begin
         w_mem[j2_ff] <= wnew_c;
      end
      if (cmd.rd) w_rd_ff <= w_mem[cnt[TW-1:0]];
   end

   // pass pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         p1_ff <= 1'b0;
         p2_ff <= 1'b0;
      end else begin
         s1_ff <= cmd.rd;
         s2_ff <= s1_ff;
         p1_ff <= cmd.pass2;
         p2_ff <= p1_ff;
      end
   end

   // product stage
   assign sq_c = x_rd_ff * x_rd_ff;

   always_ff @(posedge clock) begin
      j1_ff   <= cnt[TW-1:0];
      j2_ff   <= j1_ff;
      prod_ff <= w_rd_ff * x_rd_ff;
      sq_ff   <= sq_c[30:0];
      pw_ff   <= $signed({1'b0, ck_c}) * w_rd_ff;
      px_ff   <= c1_c * x_rd_ff;
   end

   // accumulate dot product and energy
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff   <= '0;
         sigma_ff <= '0;
         x0_ff    <= sample_in;
      end else if (s2_ff && !p2_ff) begin
         acc_ff   <= acc_ff + ACCW'(prod_ff);
         sigma_ff <= sigma_ff + SIGW'(sq_ff);
      end
   end

   assign status.sigma_zero = (sigma_ff == '0);

   // prediction, error and saturated result
   assign accr_c = acc_ff + (ACCW'(1) <<< 29);
   assign y_c    = $signed(accr_c[ACCW-1:30]);
   assign e_c    = EW'(x0_ff) - EW'(y_c);
   assign res_c  = cfg.notch_mode ? e_c : EW'(y_c);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (res_c > EW'(32767))       out_ff <= 16'sh7fff;
         else if (res_c < EW'(-32768)) out_ff <= 16'sh8000;
         else                          out_ff <= res_c[15:0];
      end
      if (cmd.latch_err) begin
         y_ff <= y_c;
         e_ff <= e_c;
      end
   end

   assign sample_out = out_ff;

   // leakage times step size, q0.24
   assign gmul_c = cfg.two_mu * gamma_ff;
   assign ck_c   = 25'h100_0000 - {1'b0, g_ff};
   assign m_c    = status.sigma_zero ? '0 : cfg.two_mu;
   assign km_c   = 25'h100_0000 - {1'b0, m_c};

   always_ff @(posedge clock) begin
      if (cmd.calc_g) g_ff <= gmul_c[55:32];
   end

   // error measure products
   always_ff @(posedge clock) begin
      if (cmd.err_mul) begin
         nelp_ff <= $signed({1'b0, km_c}) * e_ff;
         gy_ff   <= $signed({1'b0, ck_c}) * y_ff;
         num_ff  <= $signed({1'b0, cfg.two_mu}) * e_ff;
      end
   end

   always_comb begin
      nel_s = NW'(nelp_ff);
      nev_s = (NW'(x0_ff) <<< 24) - NW'(gy_ff)
            - (status.sigma_zero ? NW'(0) : NW'(num_ff));
      nel_a = nel_s[NW-1] ? NW'(-nel_s) : NW'(nel_s);
      nev_a = nev_s[NW-1] ? NW'(-nev_s) : NW'(nev_s);
   end

   // leakage index step, clamped to the limit it crosses
   always_comb begin
      up_c = {1'b0, idx_ff} + {1'b0, cfg.lidx_inc};
      dn_c = $signed({2'b00, idx_ff}) - $signed({2'b00, cfg.lidx_dec});
      if (nev_a < nel_a) begin
         idx_c = (up_c > {1'b0, cfg.lidx_max}) ? cfg.lidx_max : up_c[7:0];
      end else begin
         idx_c = (dn_c < $signed({2'b00, cfg.lidx_min})) ? cfg.lidx_min : dn_c[7:0];
      end
   end

   // index, its fourth power and the leakage
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= lnr_pkg::LIDX_RESET;
         gamma_ff <= '0;
      end else begin
         if (cmd.err_cmp) idx_ff <= idx_c;
         if (cmd.gam4)    gamma_ff <= (lg_ff[63:48] != '0) ? 32'hffff_ffff : lg_ff[47:16];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.gam1) i2_ff <= idx_ff * idx_ff;
      if (cmd.gam2) i4_ff <= i2_ff * i2_ff;
      if (cmd.gam3) lg_ff <= cfg.leak_scale * i4_ff;
   end

   // step size two_mu*e/sigma, one quotient bit a cycle
   assign an_c    = num_ff[NUMW-1] ? NUMW'(-num_ff) : NUMW'(num_ff);
   assign trial_c = {rem_ff, dq_ff[QW-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff  <= SIGW'(an_c >> 10);
         dq_ff   <= {an_c[9:0], {(QW - 10){1'b0}}};
         q_ff    <= '0;
         zero_ff <= status.sigma_zero;
         sat_ff  <= (DW'(an_c) >= (DW'(sigma_ff) << 10));
         neg_ff  <= num_ff[NUMW-1];
      end else if (cmd.div_step) begin
         dq_ff <= dq_ff << 1;
         if (trial_c >= {1'b0, sigma_ff}) begin
            rem_ff <= SIGW'(trial_c - {1'b0, sigma_ff});
            q_ff   <= {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= trial_c[SIGW-1:0];
            q_ff   <= {q_ff[QW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      mag_c = sat_ff ? {QW{1'b1}} : q_ff;
      if (zero_ff)     c1_c = '0;
      else if (neg_ff) c1_c = -$signed({1'b0, mag_c});
      else             c1_c = $signed({1'b0, mag_c});
   end

   // leaky weight update with rounding and saturation
   always_comb begin
      pwr_c  = pw_ff + (58'sd1 <<< 23);
      pxr_c  = px_ff + (48'sd1 <<< 14);
      wa_c   = $signed(pwr_c[57:24]);
      wb_c   = $signed(pxr_c[47:15]);
      wsum_c = 35'(wa_c) + 35'(wb_c);
      if (wsum_c > 35'sd2147483647)       wnew_c = 32'sh7fff_ffff;
      else if (wsum_c < -35'sd2147483648) wnew_c = 32'sh8000_0000;
      else                                wnew_c = wsum_c[31:0];
   end

endmodule

[rtl/leaky_nlms_noise_reducer.sv]
// channel | ports                          | moves
// req     | req_valid/req_ready            | one item: req_sample_in
// rsp     | rsp_valid/rsp_ready            | one item: rsp_sample_out
// csr     | csr_psel/penable/pwrite/paddr  | register writes and reads
//
// an item makes two passes over the taps through the line store and
// weight memory, plus a bit-serial divide for the step size; a silent
// window skips the divide. a new item is taken only once the last one
// is through.
// after reset a clearing pass over max(BUF_DEPTH, TAPS) addresses zeroes both
// memories; req_ready stays low until it ends.
// a result waiting in the output register stalls the next item only at
// the point where its own result is loaded.
module leaky_nlms_noise_reducer #(
   parameter int TAPS      = lnr_pkg::TAPS_DEF,
   parameter int BUF_DEPTH = lnr_pkg::BUF_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_sample_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample_out,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int CLRN = (BUF_DEPTH > TAPS) ? BUF_DEPTH : TAPS;
   localparam int CW   = $clog2(CLRN + 3);

   lnr_pkg::cfg_type    cfg_ff, cfg_in;
   lnr_pkg::cmd_type    cmd;
   lnr_pkg::status_type status;
   logic [CW-1:0]       cnt;
   logic                csr_wr;
   logic [2:0]          csr_idx;

   // register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            lnr_pkg::REG_NOTCH_MODE: cfg_in.notch_mode = csr_pwdata[0];
            lnr_pkg::REG_DELAY_TAPS: cfg_in.delay_taps = csr_pwdata[7:0];
            lnr_pkg::REG_TWO_MU:     cfg_in.two_mu     = csr_pwdata[23:0];
            lnr_pkg::REG_LEAK_SCALE: cfg_in.leak_scale = csr_pwdata;
            lnr_pkg::REG_LIDX_MIN:   cfg_in.lidx_min   = csr_pwdata[7:0];
            lnr_pkg::REG_LIDX_MAX:   cfg_in.lidx_max   = csr_pwdata[7:0];
            lnr_pkg::REG_LIDX_INC:   cfg_in.lidx_inc   = csr_pwdata[7:0];
            lnr_pkg::REG_LIDX_DEC:   cfg_in.lidx_dec   = csr_pwdata[7:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.notch_mode <= lnr_pkg::NOTCH_MODE_RST;
         cfg_ff.delay_taps <= lnr_pkg::DELAY_TAPS_RST;
         cfg_ff.two_mu     <= lnr_pkg::TWO_MU_RST;
         cfg_ff.leak_scale <= lnr_pkg::LEAK_SCALE_RST;
         cfg_ff.lidx_min   <= lnr_pkg::LIDX_MIN_RST;
         cfg_ff.lidx_max   <= lnr_pkg::LIDX_MAX_RST;
         cfg_ff.lidx_inc   <= lnr_pkg::LIDX_INC_RST;
         cfg_ff.lidx_dec   <= lnr_pkg::LIDX_DEC_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register readback
   always_comb begin
      unique case (csr_idx)
         lnr_pkg::REG_NOTCH_MODE: csr_prdata = {31'd0, cfg_ff.notch_mode};
         lnr_pkg::REG_DELAY_TAPS: csr_prdata = {24'd0, cfg_ff.delay_taps};
         lnr_pkg::REG_TWO_MU:     csr_prdata = {8'd0, cfg_ff.two_mu};
         lnr_pkg::REG_LEAK_SCALE: csr_prdata = cfg_ff.leak_scale;
         lnr_pkg::REG_LIDX_MIN:   csr_prdata = {24'd0, cfg_ff.lidx_min};
         lnr_pkg::REG_LIDX_MAX:   csr_prdata = {24'd0, cfg_ff.lidx_max};
         lnr_pkg::REG_LIDX_INC:   csr_prdata = {24'd0, cfg_ff.lidx_inc};
         lnr_pkg::REG_LIDX_DEC:   csr_prdata = {24'd0, cfg_ff.lidx_dec};
         default:                 csr_prdata = '0;
      endcase
   end

   // sequencer
   lnr_ctrl #(
      .TAPS      (TAPS),
      .BUF_DEPTH (BUF_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd),
      .cnt       (cnt)
   );

   // arithmetic and memories
   lnr_dp #(
      .TAPS      (TAPS),
      .BUF_DEPTH (BUF_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .cnt        (cnt),
      .sample_in  (req_sample_in),
      .sample_out (rsp_sample_out),
      .status     (status)
   );

`ifndef NO_ASSERTIONS
   // sample is written exactly when an item is taken
   a_load_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_valid && req_ready))
      else $error("sample write without item accept");

   // a loaded result shows up as valid next cycle
   a_load_out: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("result loaded but not presented");

   // no item accepted during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.clr |-> !req_ready)
      else $error("item accepted while clearing");

   // divider never runs on a silent window
   a_div_sigma: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !status.sigma_zero)
      else $error("divide by zero energy");
`endif

endmodule

[sim/leaky_nlms_noise_reducer_test.sv]
module leaky_nlms_noise_reducer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TAPS  = 64;
   localparam int DEPTH = 256;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_sample_out;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   leaky_nlms_noise_reducer i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [15:0] hist [DEPTH];
   logic signed [31:0] wts [TAPS];
   logic [7:0] wr_ptr;
   logic [7:0] lidx;
   logic [31:0] gamma_q;
   lnr_pkg::cfg_type cfg;
   // expected results, in order
   logic signed [15:0] exp_mem [1024];
   int exp_wr = 0;
   int exp_rd = 0;
   int errors = 0;
   int stall_cnt = 0;
   bit rsp_stall_on = 1'b1;

   function automatic void exp_store(logic signed [15:0] v);
      exp_mem[exp_wr[9:0]] = v;
      exp_wr++;
   endfunction

   function automatic longint rshift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint labs(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint g24();
      longint unsigned p;
      p = longint'(cfg.two_mu) * longint'(gamma_q);
      return longint'(p >> 32);
   endfunction

   // one sample through the predictor model
   function automatic logic signed [15:0] nlms_predict(logic signed [15:0] xin);
      longint acc, y, e, m, g, nel, nev, num, c1, res, xv, wv;
      longint unsigned sigma, q4, an, mag, q1, r1;
      int li;
      logic [7:0] a;
      logic signed [15:0] outv;
      acc = 0;
      sigma = 0;
      c1 = 0;
      hist[wr_ptr] = xin;
      for (int j = 0; j < TAPS; j++) begin
         a = wr_ptr + j[7:0] + cfg.delay_taps;
         xv = hist[a];
         acc += longint'(wts[j]) * xv;
         sigma += longint'(xv * xv);
      end
      y = rshift(acc, 30);
      e = longint'(xin) - y;
      res = cfg.notch_mode ? e : y;
      outv = res < -32768 ? 16'sh8000 : (res > 32767 ? 16'sh7FFF : 16'(res));
      m = (sigma != 0) ? longint'(cfg.two_mu) : 0;
      g = g24();
      nel = labs(e * (64'sd16777216 - m));
      nev = labs(longint'(xin) * 16777216 - (64'sd16777216 - g) * y - m * e);
      li = lidx;
      if (nev < nel) begin
         li += cfg.lidx_inc;
         if (li > int'(cfg.lidx_max)) li = cfg.lidx_max;
      end else begin
         li -= cfg.lidx_dec;
         if (li < int'(cfg.lidx_min)) li = cfg.lidx_min;
      end
      lidx = li[7:0];
      q4 = longint'(lidx) * longint'(lidx);
      q4 = q4 * q4;
      q4 = (longint'(cfg.leak_scale) * q4) >> 16;
      gamma_q = q4 > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q4[31:0];
      g = g24();
      if (sigma != 0) begin
         num = longint'(cfg.two_mu) * e;
         an = labs(num);
         if (an >= (sigma << 10)) mag = 64'h7FFF_FFFF;
         else begin
            q1 = an / sigma;
            r1 = an % sigma;
            mag = (q1 << 21) + ((r1 << 21) / sigma);
            if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
         end
         c1 = num < 0 ? -longint'(mag) : longint'(mag);
      end
      for (int j = 0; j < TAPS; j++) begin
         a = wr_ptr + j[7:0] + cfg.delay_taps;
         xv = hist[a];
         wv = rshift((64'sd16777216 - g) * wts[j], 24) + rshift(c1 * xv, 15);
         if (wv > 64'sd2147483647) wv = 64'sd2147483647;
         if (wv < -64'sd2147483648) wv = -64'sd2147483648;
         wts[j] = 32'(wv);
      end
      wr_ptr = wr_ptr - 8'd1;
      return outv;
   endfunction

   // random gap, mostly short, sometimes long
   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // valid stays high between back-to-back items, dropped before a gap
   task automatic send_sample(logic signed [15:0] s);
      int gap;
      gap = rand_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      exp_store(nlms_predict(s));
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         lnr_pkg::REG_NOTCH_MODE: cfg.notch_mode = val[0];
         lnr_pkg::REG_DELAY_TAPS: cfg.delay_taps = val[7:0];
         lnr_pkg::REG_TWO_MU:     cfg.two_mu = val[23:0];
         lnr_pkg::REG_LEAK_SCALE: cfg.leak_scale = val;
         lnr_pkg::REG_LIDX_MIN:   cfg.lidx_min = val[7:0];
         lnr_pkg::REG_LIDX_MAX:   cfg.lidx_max = val[7:0];
         lnr_pkg::REG_LIDX_INC:   cfg.lidx_inc = val[7:0];
         lnr_pkg::REG_LIDX_DEC:   cfg.lidx_dec = val[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // audio-like random sample: mix of tones, noise and full scale
   function automatic logic signed [15:0] rand_sample(int n);
      int k;
      k = $urandom_range(0, 9);
      if (k < 5) return 16'($rtoi(9000.0 * $sin(n * 0.3)) + $urandom_range(0, 2000) - 1000);
      if (k < 8) return 16'($urandom);
      if (k == 8) return 16'sh7FFF;
      return 16'sh8000;
   endfunction

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (exp_wr == exp_rd) begin
            $display("%0t: unexpected item, actual %0d", $time, rsp_sample_out);
            errors++;
         end else begin
            logic signed [15:0] exp_s;
            exp_s = exp_mem[exp_rd[9:0]];
            exp_rd++;
            if (exp_s !== rsp_sample_out) begin
               $display("%0t: sample_out expected %0d actual %0d", $time, exp_s,
                        rsp_sample_out);
               errors++;
            end
         end
      end
   end

   // receiver stall: ready, then a random gap of not ready; always ready when stalling is off
   always @(posedge clock) begin
      if (!rsp_stall_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_cnt > 0) begin
         rsp_ready <= 1'b0;
         stall_cnt--;
      end else begin
         rsp_ready <= 1'b1;
         stall_cnt = rand_gap();
      end
   end

   task automatic test_directed();
      logic signed [15:0] pts [] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                                     16'sh0001, 16'sh5555, 16'shAAAA};
      foreach (pts[i]) send_sample(pts[i]);
      // silent window stays silent at first; then an impulse train
      for (int i = 0; i < 12; i++) send_sample(i % 4 == 0 ? 16'sh4000 : 16'sh0000);
      wait_drained();
      write_reg(lnr_pkg::REG_NOTCH_MODE, 32'd1);
      for (int i = 0; i < 6; i++) send_sample(rand_sample(i));
      wait_drained();
   endtask

   task automatic test_config_sweep();
      write_reg(lnr_pkg::REG_DELAY_TAPS, 32'd0);
      write_reg(lnr_pkg::REG_TWO_MU, 32'hFFFFFF);
      write_reg(lnr_pkg::REG_LEAK_SCALE, 32'hFFFF_FFFF);
      write_reg(lnr_pkg::REG_LIDX_MIN, 32'd0);
      write_reg(lnr_pkg::REG_LIDX_MAX, 32'd255);
      write_reg(lnr_pkg::REG_LIDX_INC, 32'd255);
      write_reg(lnr_pkg::REG_LIDX_DEC, 32'd255);
      for (int i = 0; i < 100; i++) send_sample(rand_sample(i));
      wait_drained();
      // crossed limits
      write_reg(lnr_pkg::REG_DELAY_TAPS, 32'd192);
      write_reg(lnr_pkg::REG_LIDX_MIN, 32'd200);
      write_reg(lnr_pkg::REG_LIDX_MAX, 32'd50);
      write_reg(lnr_pkg::REG_LIDX_INC, 32'd0);
      write_reg(lnr_pkg::REG_LIDX_DEC, 32'd7);
      write_reg(lnr_pkg::REG_TWO_MU, 32'd0);
      write_reg(lnr_pkg::REG_LEAK_SCALE, 32'd0);
      write_reg(lnr_pkg::REG_NOTCH_MODE, 32'd0);
      for (int i = 0; i < 100; i++) send_sample(rand_sample(i));
      wait_drained();
   endtask

   task automatic test_random();
      for (int p = 0; p < 6; p++) begin
         write_reg(lnr_pkg::REG_NOTCH_MODE, $urandom_range(0, 1));
         write_reg(lnr_pkg::REG_DELAY_TAPS, $urandom_range(0, 192));
         write_reg(lnr_pkg::REG_TWO_MU, $urandom_range(0, 200000));
         write_reg(lnr_pkg::REG_LEAK_SCALE, $urandom);
         write_reg(lnr_pkg::REG_LIDX_MIN, $urandom_range(0, 255));
         write_reg(lnr_pkg::REG_LIDX_MAX, $urandom_range(0, 255));
         write_reg(lnr_pkg::REG_LIDX_INC, $urandom_range(0, 255));
         write_reg(lnr_pkg::REG_LIDX_DEC, $urandom_range(0, 255));
         rsp_stall_on = (p % 3 != 2);
         for (int i = 0; i < 110; i++) send_sample(rand_sample(i));
         wait_drained();
      end
   endtask

   initial begin
      foreach (hist[i]) hist[i] = '0;
      foreach (wts[i]) wts[i] = '0;
      wr_ptr = '0;
      lidx = lnr_pkg::LIDX_RESET;
      gamma_q = '0;
      cfg = '{lnr_pkg::NOTCH_MODE_RST, lnr_pkg::DELAY_TAPS_RST, lnr_pkg::TWO_MU_RST,
              lnr_pkg::LEAK_SCALE_RST, lnr_pkg::LIDX_MIN_RST, lnr_pkg::LIDX_MAX_RST,
              lnr_pkg::LIDX_INC_RST, lnr_pkg::LIDX_DEC_RST};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_sweep();
      test_random();
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // run limit
   initial begin
      #50ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
